// ----- rtl/otoh_pkg.sv -----
// Shared types and codes for the ownership token handshake unit.
// No dependencies; used by otoh_step and ownership_token_handshake_unit.
package otoh_pkg;

    // Action codes carried in the transaction's action field
    typedef enum logic [2:0] {
        ACT_INIT          = 3'd0,
        ACT_REQUEST       = 3'd1,
        ACT_PEER_REQUEST  = 3'd2,
        ACT_GRANT         = 3'd3,
        ACT_DENY          = 3'd4,
        ACT_PEER_RESPONSE = 3'd5,
        ACT_QUERY         = 3'd6
    } t_action;

    // Message kinds reported in msg_kind
    localparam logic [1:0] MSG_NONE     = 2'd0;
    localparam logic [1:0] MSG_REQUEST  = 2'd1;
    localparam logic [1:0] MSG_RESPONSE = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_OWNER = 4'd1;
    localparam logic [31:0]          TIMEOUT_RESET  = 32'd1000;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  category;
        logic [31:0] nonce_in;
        logic        grant_in;
        logic [31:0] now_ticks;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  msg_kind;
        logic [31:0] msg_nonce;
        logic        msg_grant;
        logic        owns;
        logic        request_pending;
        logic        incoming_pending;
    } t_out_item;

    // One category's stored state
    typedef struct packed {
        logic        owns;
        logic        out_active;
        logic [31:0] out_nonce;
        logic [31:0] out_sent_time;
        logic        in_active;
        logic [31:0] in_nonce;
        logic [31:0] in_received_time;
    } t_entry;

endpackage

// ----- rtl/otoh_step.sv -----
// Combinational step for one category entry: decodes the action, checks slot age
// against the timeout and builds the new entry plus the result transaction.
// Depends on otoh_pkg.
module otoh_step (
    input  otoh_pkg::t_in_item  i_item,
    input  otoh_pkg::t_entry    i_entry,
    input  logic [31:0]         i_timeout,
    input  logic [31:0]         i_nonce_ctr,
    output otoh_pkg::t_entry    o_entry,
    output otoh_pkg::t_out_item o_result,
    output logic                o_bump
);

    logic [31:0] out_age;
    logic [31:0] in_age;
    logic        out_live;
    logic        in_live;
    logic        tmo_nz;
    logic        out_live_post;
    logic        in_live_post;

    assign out_age  = i_item.now_ticks - i_entry.out_sent_time;
    assign in_age   = i_item.now_ticks - i_entry.in_received_time;
    assign out_live = i_entry.out_active && (out_age < i_timeout);
    assign in_live  = i_entry.in_active && (in_age < i_timeout);
    // a freshly stamped slot has age zero, live for any nonzero timeout
    assign tmo_nz   = (i_timeout != 32'd0);

    always_comb begin
        o_entry            = i_entry;
        o_bump             = 1'b0;
        o_result.msg_kind  = otoh_pkg::MSG_NONE;
        o_result.msg_nonce = 32'd0;
        o_result.msg_grant = 1'b0;
        out_live_post      = out_live;
        in_live_post       = in_live;
        case (i_item.action)
            otoh_pkg::ACT_REQUEST: begin
                if (!i_entry.owns) begin
                    o_result.msg_kind = otoh_pkg::MSG_REQUEST;
                    if (out_live) begin
                        o_result.msg_nonce = i_entry.out_nonce;
                    end else begin
                        o_entry.out_active    = 1'b1;
                        o_entry.out_nonce     = i_nonce_ctr;
                        o_entry.out_sent_time = i_item.now_ticks;
                        o_bump                = 1'b1;
                        o_result.msg_nonce    = i_nonce_ctr;
                        out_live_post         = tmo_nz;
                    end
                end
            end
            otoh_pkg::ACT_PEER_REQUEST: begin
                o_entry.in_active        = 1'b1;
                o_entry.in_nonce         = i_item.nonce_in;
                o_entry.in_received_time = i_item.now_ticks;
                in_live_post             = tmo_nz;
            end
            otoh_pkg::ACT_GRANT, otoh_pkg::ACT_DENY: begin
                if (in_live) begin
                    o_result.msg_kind  = otoh_pkg::MSG_RESPONSE;
                    o_result.msg_nonce = i_entry.in_nonce;
                    o_entry.in_active  = 1'b0;
                    in_live_post       = 1'b0;
                    if (i_item.action == otoh_pkg::ACT_GRANT) begin
                        o_result.msg_grant = 1'b1;
                        o_entry.owns       = 1'b0;
                    end
                end
            end
            otoh_pkg::ACT_PEER_RESPONSE: begin
                if (out_live && (i_entry.out_nonce == i_item.nonce_in)) begin
                    o_entry.out_active = 1'b0;
                    out_live_post      = 1'b0;
                    if (i_item.grant_in) begin
                        o_entry.owns = 1'b1;
                    end
                end
            end
            default: begin
                // init, query and the unused code: no change to this entry
            end
        endcase
        o_result.owns             = o_entry.owns;
        o_result.request_pending  = out_live_post;
        o_result.incoming_pending = in_live_post;
    end

endmodule

// ----- rtl/ownership_token_handshake_unit.sv -----
// Ownership token handshake unit: per-category ownership flags with outgoing and
// incoming request slots. Depends on otoh_pkg and otoh_step.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one action
//   transaction per accepted cycle; output channel (o_out_valid / i_out_stall /
//   o_out_item) returns exactly one result transaction for each of them, in order.
//   Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) writes
//   timeout_ticks (index 0) or initial_owner (index 1); other indexes are dropped.
//   Write configuration only while no transaction is in flight.
// Pipeline: an accepted transaction is held in the input register, then moves into
//   the result register; one transaction per cycle sustained while the output does
//   not stall. The input register feeds one pass of otoh_step (two 32-bit age
//   subtract/compares) straight into the result register, and state is written back
//   on that same edge, so the next transaction always sees updated state.
// Reset: all ownership flags clear, all slots inactive, nonce counter zero,
//   timeout 1000, initial_owner 0. Nonce and timestamp storage is not cleared.
// Stall: while i_out_stall holds a valid result, the input register fills and
//   then o_in_stall rises in the same cycle; nothing is lost or repeated.
module ownership_token_handshake_unit #(
    parameter int NUM_CATEGORIES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  otoh_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output otoh_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [otoh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    localparam int IDX_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

    // Input and result stages
    logic                r_in_valid;
    otoh_pkg::t_in_item  r_in;
    logic                r_out_valid;
    otoh_pkg::t_out_item r_out;

    // Configuration
    logic [31:0] r_timeout;
    logic        r_init_owner;

    // Per-category state
    logic        r_owns       [NUM_CATEGORIES];
    logic        r_out_active [NUM_CATEGORIES];
    logic [31:0] r_out_nonce  [NUM_CATEGORIES];
    logic [31:0] r_out_sent   [NUM_CATEGORIES];
    logic        r_in_active  [NUM_CATEGORIES];
    logic [31:0] r_in_nonce   [NUM_CATEGORIES];
    logic [31:0] r_in_recv    [NUM_CATEGORIES];
    logic [31:0] r_nonce_ctr;

    logic                out_free;
    logic                advance;
    logic                is_init;
    logic                in_range;
    logic [IDX_W+2:0]    cat_ext;
    logic [IDX_W-1:0]    idx;
    otoh_pkg::t_entry    cur_entry;
    otoh_pkg::t_entry    n_entry;
    otoh_pkg::t_out_item step_result;
    otoh_pkg::t_out_item n_out;
    logic                step_bump;
    logic                wb_en;

    // Result register may load when empty or when its transaction leaves now
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // Select the entry; out-of-range categories change nothing but the init reload
    assign cat_ext  = {{IDX_W{1'b0}}, r_in.category};
    assign idx      = cat_ext[IDX_W-1:0];
    assign in_range = ({29'd0, r_in.category} < 32'(NUM_CATEGORIES));
    assign is_init  = (r_in.action == otoh_pkg::ACT_INIT);

    // Init reloads ownership before the category's own step runs
    always_comb begin
        cur_entry.owns             = is_init ? r_init_owner : r_owns[idx];
        cur_entry.out_active       = r_out_active[idx];
        cur_entry.out_nonce        = r_out_nonce[idx];
        cur_entry.out_sent_time    = r_out_sent[idx];
        cur_entry.in_active        = r_in_active[idx];
        cur_entry.in_nonce         = r_in_nonce[idx];
        cur_entry.in_received_time = r_in_recv[idx];
    end

    otoh_step u_step (
        .i_item      (r_in),
        .i_entry     (cur_entry),
        .i_timeout   (r_timeout),
        .i_nonce_ctr (r_nonce_ctr),
        .o_entry     (n_entry),
        .o_result    (step_result),
        .o_bump      (step_bump)
    );

    assign wb_en = advance && in_range;
    // Out-of-range categories report all zero fields
    assign n_out = in_range ? step_result : '0;

    // Handshake and configuration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_timeout    <= otoh_pkg::TIMEOUT_RESET;
            r_init_owner <= 1'b0;
            r_nonce_ctr  <= 32'd0;
        end else begin
            // hold the input register while its transaction cannot move on
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    otoh_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                    otoh_pkg::CFG_INIT_OWNER: r_init_owner <= i_cfg_data[0];
                    default: begin
                        // drop writes to unknown registers
                    end
                endcase
            end
            if (wb_en && step_bump) begin
                r_nonce_ctr <= r_nonce_ctr + 32'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Ownership and slot active bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CATEGORIES; i++) begin
                r_owns[i]       <= 1'b0;
                r_out_active[i] <= 1'b0;
                r_in_active[i]  <= 1'b0;
            end
        end else begin
            for (int i = 0; i < NUM_CATEGORIES; i++) begin
                // the stepped entry already carries the init owner
                if (wb_en && (idx == IDX_W'(i))) begin
                    r_owns[i]       <= n_entry.owns;
                    r_out_active[i] <= n_entry.out_active;
                    r_in_active[i]  <= n_entry.in_active;
                end else if (advance && is_init) begin
                    r_owns[i] <= r_init_owner;
                end
            end
        end
    end

    // Nonce and timestamp storage, valid only behind its active bit
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_CATEGORIES; i++) begin
            if (wb_en && (idx == IDX_W'(i))) begin
                r_out_nonce[i] <= n_entry.out_nonce;
                r_out_sent[i]  <= n_entry.out_sent_time;
                r_in_nonce[i]  <= n_entry.in_nonce;
                r_in_recv[i]   <= n_entry.in_received_time;
            end
        end
    end

    // The nonce counter moves only with a transaction passing through
    a_ctr_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_nonce_ctr))
        else $error("nonce counter changed without a transaction");

    // A request message is never emitted for an owned category
    a_request_not_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.msg_kind == otoh_pkg::MSG_REQUEST)) |-> !r_out.owns)
        else $error("request emitted while owning the category");

    // Answering a peer request closes the incoming slot
    a_response_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.msg_kind == otoh_pkg::MSG_RESPONSE))
            |-> !r_out.incoming_pending)
        else $error("incoming slot still pending after a response");

    // A granted response gives up ownership
    a_grant_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.msg_grant)
            |-> ((r_out.msg_kind == otoh_pkg::MSG_RESPONSE) && !r_out.owns))
        else $error("grant reported without a response or with ownership kept");

    // A new transaction always lands in the result register when it is free
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> r_out_valid)
        else $error("transaction lost between input and result register");

endmodule
